// File: src/olv_pkg.sv
// Shared types and constants of the ordered value list.
`timescale 1ns / 1ps
package olv_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W = 32;
	localparam int REQ_W = 3;
	localparam int STATUS_W = 2;
	localparam int POS_W = 4;
	localparam int FILL_W = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_SEARCH = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_DUMP   = 3'd4
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic [VALUE_W-1:0] key;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

endpackage

// File: src/olv_if.sv
// Request and response channel interfaces of the ordered value list.
`timescale 1ns / 1ps
interface olv_req_if;
	logic valid;
	logic ready;
	logic [2:0] req_type;
	logic signed [31:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface

interface olv_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic signed [31:0] item_value;
	logic [3:0] position;
	logic [4:0] fill_count;
	logic last;

	modport source (output valid, output status, output item_value, output position,
		output fill_count, output last, input ready);
	modport sink (input valid, input status, input item_value, input position,
		input fill_count, input last, output ready);
endinterface

// File: src/olv_cell.sv
// One storage cell of the list chain: holds a value, compares it, moves it.
`timescale 1ns / 1ps
module olv_cell
	import olv_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int INDEX = 0
) (
	input  logic clk,
	input  cell_ctl_t ctl,
	input  logic [$clog2(CAPACITY+1)-1:0] count,
	input  logic [VALUE_W-1:0] next_data,
	input  logic [VALUE_W-1:0] wrap_data,
	input  logic hit_up_in,
	output logic hit_up_out,
	input  logic found_dn_in,
	output logic found_dn_out,
	output logic first,
	output logic [VALUE_W-1:0] data
);

	localparam int CW = $clog2(CAPACITY+1);
	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [VALUE_W-1:0] data_q;
	logic occ;
	logic match;

	assign occ = IDX < count;
	assign match = occ && (data_q == ctl.key);
	assign hit_up_out = hit_up_in | match;
	assign found_dn_out = found_dn_in | match;
	assign first = match & ~found_dn_in;
	assign data = data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (IDX == count) data_q <= ctl.key;
			end
			CELL_SHIFT: data_q <= next_data;
			CELL_DELETE: begin
				if (!hit_up_in) data_q <= next_data;
			end
			CELL_ROTATE: begin
				if (IDX + CW'(1) == count) data_q <= wrap_data;
				else data_q <= next_data;
			end
			default: data_q <= data_q;
		endcase
	end

endmodule

// File: src/ordered_value_list.sv
// Top level of the ordered value list: control, response register and cell chain.
//
// Usage: requests enter on req (valid/ready, fields req_type and value) and
// results leave on rsp (valid/ready, fields status, item_value, position,
// fill_count, last). Values are held oldest first in a chain of CAPACITY
// cells; every cell compares its value with the request value in parallel.
// Insert, remove, search, delete and unused codes give one result, registered,
// in the cycle after the request is accepted. A request is accepted whenever
// the response register is empty or being taken, so these requests sustain one
// per cycle.
// Dump first enters the dump state, then gives one result per cycle while the
// response register is free, as the chain rotates by one place, cell zero
// feeding the response; last marks the final result. An empty list gives one
// result at once. No request is accepted during a dump.
// When the receiver stalls, the result holds in the response register and
// the chain holds too. Reset empties the list and the response register;
// cell contents are not cleared.
`timescale 1ns / 1ps
module ordered_value_list
	import olv_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	olv_req_if.sink req,
	olv_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY+1);
	localparam int IW = $clog2(CAPACITY);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] dump_idx_q, dump_idx_d;

	logic rsp_valid_q, rsp_valid_d;
	status_t status_q, status_d;
	logic [VALUE_W-1:0] item_q, item_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic last_q, last_d;

	cell_ctl_t ctl;
	logic [VALUE_W-1:0] data [CAPACITY];
	logic [CAPACITY:0] hit_up;
	logic [CAPACITY:0] found_dn;
	logic [CAPACITY-1:0] first;
	logic [IW-1:0] first_idx;
	logic slot_free;
	logic accept;
	logic dump_last;

	assign hit_up[CAPACITY] = 1'b0;
	assign found_dn[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		olv_cell #(
			.CAPACITY(CAPACITY),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.count(count_q),
			.next_data(data[(i + 1) % CAPACITY]),
			.wrap_data(data[0]),
			.hit_up_in(hit_up[i+1]),
			.hit_up_out(hit_up[i]),
			.found_dn_in(found_dn[i]),
			.found_dn_out(found_dn[i+1]),
			.first(first[i]),
			.data(data[i])
		);
	end

	always_comb begin
		first_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			first_idx = first_idx | (IW'(i) & {IW{first[i]}});
		end
	end

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept = req.valid && req.ready;
	assign dump_last = (CW'(dump_idx_q) + CW'(1)) == count_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		dump_idx_d = dump_idx_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		status_d = status_q;
		item_d = item_q;
		pos_d = pos_q;
		last_d = last_q;
		ctl.op = CELL_HOLD;
		ctl.key = req.value;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_valid_d = 1'b1;
					status_d = ST_OK;
					item_d = '0;
					pos_d = '0;
					last_d = 1'b1;
					case (req_t'(req.req_type))
						REQ_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								status_d = ST_FULL;
							end else begin
								ctl.op = CELL_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						REQ_REMOVE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								ctl.op = CELL_SHIFT;
								count_d = count_q - CW'(1);
							end
						end
						REQ_SEARCH: begin
							if (hit_up[0]) pos_d = POS_W'(first_idx);
							else status_d = ST_NOT_FOUND;
						end
						REQ_DELETE: begin
							if (hit_up[0]) begin
								ctl.op = CELL_DELETE;
								count_d = count_q - CW'(1);
							end else begin
								status_d = ST_NOT_FOUND;
							end
						end
						REQ_DUMP: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								rsp_valid_d = 1'b0;
								dump_idx_d = '0;
								state_d = S_DUMP;
							end
						end
						default: status_d = ST_OK;
					endcase
				end
			end
			S_DUMP: begin
				if (slot_free) begin
					ctl.op = CELL_ROTATE;
					rsp_valid_d = 1'b1;
					status_d = ST_OK;
					item_d = data[0];
					pos_d = POS_W'(dump_idx_q);
					last_d = dump_last;
					dump_idx_d = dump_idx_q + IW'(1);
					if (dump_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			dump_idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			dump_idx_q <= dump_idx_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		item_q <= item_d;
		pos_q <= pos_d;
		last_q <= last_d;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.item_value = item_q;
	assign rsp.position = pos_q;
	assign rsp.fill_count = FILL_W'(count_q);
	assign rsp.last = last_q;

endmodule
